// File: design/apd_pkg.sv
`timescale 1ns / 1ps

package apd_pkg;

    localparam int CALIB_SAMPLES = 200;
    localparam int CALIB_IDX_W   = $clog2(CALIB_SAMPLES + 1);

    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 24;
    localparam int SUM_MAG_W = 23;
    localparam int BIAS_W   = 16;
    localparam int DIFF_W   = 17;
    localparam int FILT_W   = 25;
    localparam int GAIN_W   = 9;
    localparam int THR_W    = 16;
    localparam int COUNT_W  = 8;
    localparam int CFG_W    = 16;

    localparam int RECIP_SHIFT = 31;
    localparam int RECIP_W     = 32;
    localparam logic [RECIP_W-1:0] CALIB_RECIP = RECIP_W'(
        ((64'd1 << RECIP_SHIFT) + 64'(CALIB_SAMPLES) - 64'd1) / 64'(CALIB_SAMPLES));
    localparam int PROD_W = SUM_MAG_W + RECIP_W;

    localparam logic [THR_W-1:0]   LAUNCH_THRESHOLD_RST = 16'd24576;
    localparam logic [THR_W-1:0]   APOGEE_THRESHOLD_RST = 16'd1638;
    localparam logic [THR_W-1:0]   ZERO_BAND_RST        = 16'd492;
    localparam logic [GAIN_W-1:0]  FILTER_GAIN_RST      = 9'd51;
    localparam logic [COUNT_W-1:0] APOGEE_COUNT_RST     = 8'd25;
    localparam logic [GAIN_W-1:0]  GAIN_FULL            = 9'd256;
    localparam logic [COUNT_W-1:0] COUNT_MAX            = 8'd255;

    typedef enum logic [2:0] {
        CFG_LAUNCH_THRESHOLD = 3'd0,
        CFG_APOGEE_THRESHOLD = 3'd1,
        CFG_ZERO_BAND        = 3'd2,
        CFG_FILTER_GAIN      = 3'd3,
        CFG_APOGEE_COUNT     = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        PHASE_CALIB    = 2'd0,
        PHASE_WAIT     = 2'd1,
        PHASE_FLIGHT   = 2'd2,
        PHASE_APOGEE   = 2'd3
    } phase_t;

endpackage

// File: design/accel_launch_apogee_detector.sv
`timescale 1ns / 1ps

// channel   direction   handshake              payload
// in        input       in_valid / in_stall    accel_z_raw
// out       output      out_valid / out_stall  phase, filtered_accel, quiet_count
// cfg       input       cfg_write              cfg_index, cfg_data
//
// Two register stages: an input register, then one pass of logic into the result register.
// One item per cycle when not stalled; out_valid rises as the result register loads.
// After the last calibration item a bubble computes the bias (reciprocal multiply).
// Reset clears all control and detector state and loads the register defaults.
// out_stall holds the result register; the input register still fills while it waits.
module accel_launch_apogee_detector (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [apd_pkg::SAMPLE_W-1:0]     accel_z_raw,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [1:0]                              phase,
    output logic signed [apd_pkg::FILT_W-1:0]       filtered_accel,
    output logic [apd_pkg::COUNT_W-1:0]             quiet_count,
    input  logic                                    cfg_write,
    input  logic [2:0]                              cfg_index,
    input  logic [apd_pkg::CFG_W-1:0]               cfg_data
);
    import apd_pkg::*;

    logic [THR_W-1:0]   launch_thr_reg;
    logic [THR_W-1:0]   apogee_thr_reg;
    logic [THR_W-1:0]   zero_band_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic [COUNT_W-1:0] apogee_count_reg;

    logic                       in_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;

    logic [CALIB_IDX_W-1:0]     calib_index_reg;
    logic                       calib_done_reg;
    logic                       bias_pending_reg;
    logic signed [SUM_W-1:0]    calib_sum_reg;
    logic signed [BIAS_W-1:0]   bias_reg;
    logic signed [FILT_W-1:0]   filter_reg;
    logic                       launched_reg;
    logic                       apogee_reg;
    logic [COUNT_W-1:0]         run_reg;

    logic                       out_valid_reg;
    phase_t                     phase_reg;
    logic signed [FILT_W-1:0]   filt_out_reg;
    logic [COUNT_W-1:0]         quiet_out_reg;

    logic advance;
    logic accept;

    logic                       sum_neg;
    logic [SUM_W-1:0]           sum_abs;
    logic [PROD_W-1:0]          bias_prod;
    logic [BIAS_W:0]            bias_quot;
    logic [BIAS_W:0]            bias_signed;

    logic signed [DIFF_W-1:0]   diff;
    logic [DIFF_W-1:0]          diff_mag;
    logic signed [DIFF_W-1:0]   diff_z;
    logic [GAIN_W-1:0]          gain_sat;
    logic signed [GAIN_W:0]     gain_s;
    logic signed [GAIN_W:0]     keep_s;
    logic signed [DIFF_W+GAIN_W:0]      prod_new;
    logic signed [FILT_W+GAIN_W:0]      prod_old;
    logic signed [FILT_W+GAIN_W+1:0]    acc;
    logic signed [FILT_W-1:0]   y;
    logic [FILT_W-1:0]          y_mag;
    logic                       is_big;
    logic                       is_quiet;

    logic                       launched_next;
    logic                       apogee_next;
    logic [COUNT_W-1:0]         run_next;
    phase_t                     phase_next;

    assign advance  = in_valid_reg && !bias_pending_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    assign out_valid      = out_valid_reg;
    assign phase          = phase_reg;
    assign filtered_accel = filt_out_reg;
    assign quiet_count    = quiet_out_reg;

    // bias = sum / CALIB_SAMPLES, truncated toward zero
    assign sum_neg     = calib_sum_reg[SUM_W-1];
    assign sum_abs     = sum_neg ? SUM_W'(-calib_sum_reg) : SUM_W'(calib_sum_reg);
    assign bias_prod   = PROD_W'(sum_abs[SUM_MAG_W-1:0]) * PROD_W'(CALIB_RECIP);
    assign bias_quot   = bias_prod[RECIP_SHIFT+BIAS_W:RECIP_SHIFT];
    assign bias_signed = sum_neg ? (BIAS_W+1)'(-bias_quot) : bias_quot;

    always_comb
    begin
        diff     = DIFF_W'(sample_reg) - DIFF_W'(bias_reg);
        diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        diff_z   = (diff_mag < DIFF_W'(zero_band_reg)) ? '0 : diff;

        gain_sat = (gain_reg > GAIN_FULL) ? GAIN_FULL : gain_reg;
        gain_s   = $signed({1'b0, gain_sat});
        keep_s   = $signed({1'b0, GAIN_W'(GAIN_FULL - gain_sat)});
        prod_new = gain_s * diff_z;
        prod_old = keep_s * filter_reg;
        acc      = (FILT_W+GAIN_W+2)'($signed({prod_new, 8'b0}))
                 + (FILT_W+GAIN_W+2)'(prod_old);
        y        = acc[FILT_W+7:8];
        y_mag    = y[FILT_W-1] ? FILT_W'(-y) : FILT_W'(y);
        is_big   = y_mag > {1'b0, launch_thr_reg, 8'b0};
        is_quiet = y_mag < {1'b0, apogee_thr_reg, 8'b0};

        launched_next = launched_reg || is_big;
        apogee_next   = apogee_reg;
        run_next      = run_reg;
        if (launched_next && !apogee_reg)
        begin
            if (is_quiet)
            begin
                run_next = (run_reg == COUNT_MAX) ? run_reg : run_reg + 1'b1;
            end
            else
            begin
                run_next = '0;
            end
            apogee_next = run_next >= apogee_count_reg;
        end

        if (apogee_next)
        begin
            phase_next = PHASE_APOGEE;
        end
        else if (launched_next)
        begin
            phase_next = PHASE_FLIGHT;
        end
        else
        begin
            phase_next = PHASE_WAIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            launch_thr_reg   <= LAUNCH_THRESHOLD_RST;
            apogee_thr_reg   <= APOGEE_THRESHOLD_RST;
            zero_band_reg    <= ZERO_BAND_RST;
            gain_reg         <= FILTER_GAIN_RST;
            apogee_count_reg <= APOGEE_COUNT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_LAUNCH_THRESHOLD: launch_thr_reg   <= cfg_data;
                CFG_APOGEE_THRESHOLD: apogee_thr_reg   <= cfg_data;
                CFG_ZERO_BAND:        zero_band_reg    <= cfg_data;
                CFG_FILTER_GAIN:      gain_reg         <= cfg_data[GAIN_W-1:0];
                CFG_APOGEE_COUNT:     apogee_count_reg <= cfg_data[COUNT_W-1:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= accel_z_raw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calib_index_reg  <= '0;
            calib_done_reg   <= 1'b0;
            bias_pending_reg <= 1'b0;
            calib_sum_reg    <= '0;
            bias_reg         <= '0;
            filter_reg       <= '0;
            launched_reg     <= 1'b0;
            apogee_reg       <= 1'b0;
            run_reg          <= '0;
            out_valid_reg    <= 1'b0;
            phase_reg        <= PHASE_CALIB;
            filt_out_reg     <= '0;
            quiet_out_reg    <= '0;
        end
        else
        begin
            if (bias_pending_reg)
            begin
                bias_reg         <= bias_signed[BIAS_W-1:0];
                bias_pending_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                if (!calib_done_reg)
                begin
                    calib_sum_reg   <= calib_sum_reg + SUM_W'(sample_reg);
                    calib_index_reg <= calib_index_reg + 1'b1;
                    if (calib_index_reg == CALIB_IDX_W'(CALIB_SAMPLES - 1))
                    begin
                        calib_done_reg   <= 1'b1;
                        bias_pending_reg <= 1'b1;
                    end
                    phase_reg     <= PHASE_CALIB;
                    filt_out_reg  <= '0;
                    quiet_out_reg <= '0;
                end
                else
                begin
                    filter_reg    <= y;
                    launched_reg  <= launched_next;
                    apogee_reg    <= apogee_next;
                    run_reg       <= run_next;
                    phase_reg     <= phase_next;
                    filt_out_reg  <= y;
                    quiet_out_reg <= run_next;
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: bench/tb_accel_launch_apogee_detector.sv
`timescale 1ns / 1ps

module tb_accel_launch_apogee_detector;
    import apd_pkg::*;

    typedef struct {
        phase_t                   phase;
        logic signed [FILT_W-1:0] filt;
        logic [COUNT_W-1:0]       quiet;
    } detector_out_t;

    class detector_scoreboard;
        int launch_thr;
        int quiet_thr;
        int zero_band;
        int gain;
        int quiet_needed;
        int calib_seen;
        int calib_sum;
        int bias;
        longint filt_state;
        bit launched;
        bit apogee_hit;
        int quiet_run;
        int errors;
        detector_out_t expected_q[$];

        function new();
            launch_thr   = int'(LAUNCH_THRESHOLD_RST);
            quiet_thr    = int'(APOGEE_THRESHOLD_RST);
            zero_band    = int'(ZERO_BAND_RST);
            gain         = int'(FILTER_GAIN_RST);
            quiet_needed = int'(APOGEE_COUNT_RST);
            calib_seen   = 0;
            calib_sum    = 0;
            bias         = 0;
            filt_state   = 0;
            launched     = 0;
            apogee_hit   = 0;
            quiet_run    = 0;
            errors       = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [CFG_W-1:0] v);
            case (idx)
                CFG_LAUNCH_THRESHOLD: launch_thr = int'(v);
                CFG_APOGEE_THRESHOLD: quiet_thr = int'(v);
                CFG_ZERO_BAND:        zero_band = int'(v);
                CFG_FILTER_GAIN:      gain = int'(v[GAIN_W-1:0]);
                CFG_APOGEE_COUNT:     quiet_needed = int'(v[COUNT_W-1:0]);
                default: ;
            endcase
        endfunction

        function void note_input(logic signed [SAMPLE_W-1:0] x);
            detector_out_t res;
            longint d;
            longint y;
            longint mag;
            int g;
            res.phase = PHASE_CALIB;
            res.filt  = '0;
            res.quiet = '0;
            if (calib_seen < CALIB_SAMPLES) begin
                calib_sum += int'(x);
                calib_seen++;
                if (calib_seen == CALIB_SAMPLES)
                    bias = calib_sum / CALIB_SAMPLES;
            end else begin
                d = longint'(x) - longint'(bias);
                mag = (d < 0) ? -d : d;
                if (mag < longint'(zero_band))
                    d = 0;
                g = (gain > 256) ? 256 : gain;
                y = (longint'(g) * d * 256 + longint'(256 - g) * filt_state) >>> 8;
                filt_state = y;
                mag = (y < 0) ? -y : y;
                if (!launched && mag > longint'(launch_thr) * 256)
                    launched = 1;
                if (launched && !apogee_hit) begin
                    if (mag < longint'(quiet_thr) * 256) begin
                        if (quiet_run < 255)
                            quiet_run++;
                    end else begin
                        quiet_run = 0;
                    end
                    if (quiet_run >= quiet_needed)
                        apogee_hit = 1;
                end
                if (apogee_hit)
                    res.phase = PHASE_APOGEE;
                else if (launched)
                    res.phase = PHASE_FLIGHT;
                else
                    res.phase = PHASE_WAIT;
                res.filt  = FILT_W'(y);
                res.quiet = COUNT_W'(quiet_run);
            end
            expected_q.push_back(res);
        endfunction

        function void check_result(logic [1:0] ph, logic signed [FILT_W-1:0] f,
                                   logic [COUNT_W-1:0] q);
            detector_out_t e;
            if (expected_q.size() == 0) begin
                $error("result with no item pending: phase %0d filtered_accel %0d", ph, f);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (ph != e.phase) begin
                $error("phase: expected %0d, got %0d", e.phase, ph);
                errors++;
            end
            if (f != e.filt) begin
                $error("filtered_accel: expected %0d, got %0d", e.filt, f);
                errors++;
            end
            if (q != e.quiet) begin
                $error("quiet_count: expected %0d, got %0d", e.quiet, q);
                errors++;
            end
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] accel_z_raw = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [1:0]                 phase;
    logic signed [FILT_W-1:0]   filtered_accel;
    logic [COUNT_W-1:0]         quiet_count;
    logic                       cfg_write = 1'b0;
    logic [2:0]                 cfg_index = '0;
    logic [CFG_W-1:0]           cfg_data = '0;

    detector_scoreboard sb;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;

    accel_launch_apogee_detector dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .accel_z_raw    (accel_z_raw),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .phase          (phase),
        .filtered_accel (filtered_accel),
        .quiet_count    (quiet_count),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(phase, filtered_accel, quiet_count);
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic int jitter(int a);
        int r;
        r = $urandom_range(0, 2 * a);
        return r - a;
    endfunction

    function automatic int rand_sample();
        logic signed [SAMPLE_W-1:0] r;
        r = SAMPLE_W'($urandom);
        return r;
    endfunction

    task automatic set_idling(int mode);
        case (mode)
            1: begin send_idle_pct = 66; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 66; end
            3: begin send_idle_pct = 34; stall_pct = 34; end
            default: begin send_idle_pct = 0; stall_pct = 0; end
        endcase
    endtask

    task automatic send_sample(int v);
        logic signed [SAMPLE_W-1:0] s;
        if (v > 32767)
            v = 32767;
        else if (v < -32768)
            v = -32768;
        s = SAMPLE_W'(v);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        accel_z_raw <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(s);
    endtask

    // hold the input side low until every pending result is out
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, int v);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(v);
        sb.write_reg(idx, CFG_W'(v));
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int base;
        int n;
        int run;
        int push;
        int k;
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // calibration with register defaults
        set_idling(3);
        base = rand_sample();
        send_sample(32767);
        send_sample(-32768);
        while (sb.calib_seen < CALIB_SAMPLES)
            send_sample(base + jitter(2000));

        // defaults stay below launch level
        set_idling(0);
        repeat (40) send_sample(sb.bias + jitter(20000));

        drain();
        write_reg(CFG_LAUNCH_THRESHOLD, 65535);
        write_reg(CFG_ZERO_BAND, 0);
        write_reg(CFG_FILTER_GAIN, 256);
        write_reg(CFG_APOGEE_THRESHOLD, 0);
        write_reg(CFG_APOGEE_COUNT, 255);
        send_sample(32767);
        send_sample(-32768);
        send_sample(0);
        send_sample(32767);
        send_sample(-32768);
        send_sample(sb.bias);

        // gain above full scale saturates
        drain();
        write_reg(CFG_FILTER_GAIN, 511);
        send_sample(32767);
        send_sample(-32768);
        send_sample(sb.bias + 1);

        drain();
        write_reg(CFG_FILTER_GAIN, 0);
        send_sample(32767);
        send_sample(-1);

        // zero band edges
        drain();
        write_reg(CFG_FILTER_GAIN, 1);
        write_reg(CFG_ZERO_BAND, 1000);
        send_sample(sb.bias + 1000);
        send_sample(sb.bias - 1000);
        send_sample(sb.bias + 999);
        send_sample(sb.bias - 999);

        drain();
        write_reg(CFG_ZERO_BAND, 65535);
        send_sample(32767);
        send_sample(-32768);

        // waiting for launch: launch level out of reach
        for (int m = 0; m < 4; m++) begin
            drain();
            set_idling(m);
            if ($urandom_range(7) == 0)
                write_reg(CFG_FILTER_GAIN, $urandom_range(257, 511));
            else
                write_reg(CFG_FILTER_GAIN, $urandom_range(0, 256));
            if ($urandom_range(3) == 0)
                write_reg(CFG_ZERO_BAND, $urandom_range(0, 65535));
            else
                write_reg(CFG_ZERO_BAND, $urandom_range(0, 4000));
            write_reg(CFG_APOGEE_THRESHOLD, $urandom_range(0, 65535));
            if (m == 0)
                hold_requests++;
            repeat (100) begin
                if ($urandom_range(1) == 0)
                    send_sample(rand_sample());
                else
                    send_sample(sb.bias + jitter(4000));
            end
        end

        // launch
        drain();
        set_idling(3);
        write_reg(CFG_LAUNCH_THRESHOLD, ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 30000));
        write_reg(CFG_FILTER_GAIN, $urandom_range(64, 256));
        write_reg(CFG_ZERO_BAND, $urandom_range(0, 3000));
        write_reg(CFG_APOGEE_THRESHOLD, $urandom_range(500, 8000));
        push = (sb.bias >= 0) ? -32768 : 32767;
        k = 0;
        while (!sb.launched && k < 60) begin
            send_sample(push);
            k++;
        end

        // in flight: quiet runs broken by loud samples
        for (int m = 0; m < 4; m++) begin
            drain();
            set_idling(m);
            write_reg(CFG_APOGEE_THRESHOLD, $urandom_range(500, 8000));
            write_reg(CFG_ZERO_BAND, $urandom_range(0, 3000));
            n = 0;
            while (n < 40) begin
                run = $urandom_range(0, 30);
                repeat (run) begin
                    send_sample(sb.bias + jitter(300));
                    n++;
                end
                repeat ($urandom_range(1, 3)) begin
                    send_sample(rand_sample());
                    n++;
                end
            end
        end

        // apogee, with a zero count now and then
        drain();
        set_idling(2);
        write_reg(CFG_APOGEE_COUNT, ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 40));
        write_reg(CFG_APOGEE_THRESHOLD, $urandom_range(4000, 65535));
        k = 0;
        while (!sb.apogee_hit && k < 600) begin
            send_sample(sb.bias + jitter(200));
            k++;
        end

        // after apogee the filter keeps running
        set_idling(3);
        repeat (100) send_sample(rand_sample());

        set_idling(0);
        drain();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
